// ===== rtl/core/led_blink_code_sequencer_macros.svh =====
// assertion macros used by the blink-code sequencer rtl
`ifndef LED_BLINK_CODE_SEQUENCER_MACROS_SVH
`define LED_BLINK_CODE_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbc assertion failed");

`endif

// ===== rtl/core/lbc_pkg.sv =====
// types, constants and helper functions of the blink-code sequencer
package lbc_pkg;

	localparam int CODE_W   = 8;
	localparam int TENS_W   = 5;
	localparam int UNITS_W  = 4;
	localparam int DIV_RECIP = 205;  // 205 / 2048 approximates 1/10 for codes up to 255
	localparam int DIV_SHIFT = 11;
	localparam int RADIX    = 10;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TENS_ON   = 3'd1,
		PH_TENS_OFF  = 3'd2,
		PH_GAP       = 3'd3,
		PH_UNITS_ON  = 3'd4,
		PH_UNITS_OFF = 3'd5,
		PH_PAUSE     = 3'd6
	} phase_t;

	// where the skip chain starts looking for the next nonzero phase
	typedef enum logic [2:0] {
		EN_TENS  = 3'd0,
		EN_GAP   = 3'd1,
		EN_UNITS = 3'd2,
		EN_PAUSE = 3'd3,
		EN_DONE  = 3'd4
	} entry_t;

	typedef struct packed {
		logic [TENS_W-1:0]  tens;
		logic [UNITS_W-1:0] units;
	} digits_t;

	typedef struct packed {
		logic led;
		logic busy_res;
		logic done_res;
		logic rejected;
	} res_t;

	// decimal split by reciprocal multiply, exact over the 8-bit range
	function automatic digits_t split_digits(input logic [CODE_W-1:0] code);
		logic [2*CODE_W-1:0] prod;
		logic [CODE_W-1:0]   tens_w;
		logic [CODE_W-1:0]   rem;
		digits_t             d;
		prod   = code * (2*CODE_W)'(DIV_RECIP);
		tens_w = CODE_W'(prod >> DIV_SHIFT);
		rem    = code - CODE_W'(tens_w * CODE_W'(RADIX));
		d.tens  = tens_w[TENS_W-1:0];
		d.units = rem[UNITS_W-1:0];
		return d;
	endfunction

	function automatic logic lit(input phase_t p);
		return (p == PH_TENS_ON) || (p == PH_UNITS_ON);
	endfunction

endpackage

// ===== rtl/core/lbc_if.sv =====
// request and response channel interfaces of the blink-code sequencer
interface lbc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [7:0]  code;
	logic [15:0] blink_len;
	logic [15:0] gap_len;
	logic [15:0] pause_len;

	modport source (output valid, mode, code, blink_len, gap_len, pause_len, input ready);
	modport sink   (input valid, mode, code, blink_len, gap_len, pause_len, output ready);
endinterface

interface lbc_out_if;
	logic valid;
	logic ready;
	logic led;
	logic busy_res;
	logic done_res;
	logic rejected;

	modport source (output valid, led, busy_res, done_res, rejected, input ready);
	modport sink   (input valid, led, busy_res, done_res, rejected, output ready);
endinterface

// ===== rtl/core/led_blink_code_sequencer.sv =====
// top level of the led blink-code sequencer
//
// Shows an 8-bit code (0 to 255) on a status led. A start transfer (mode = 1) loads the
// code and three lengths in ticks; each tick transfer (mode = 0) then advances the sequence
// by one tick: tens-digit pulses (lit blink_len, dark blink_len), a dark gap of gap_len,
// units-digit pulses of the same form, and a dark pause of pause_len. Phases of zero length
// are skipped; a start while a sequence runs is rejected and leaves the sequence untouched.
// Lengths are held to their low TIME_BITS bits. Every request transfer yields exactly one
// response transfer. Throughput is one transfer per clock while no response waits; the
// phase and tick counters step combinationally before the output register, and the result
// reaches the response channel in the cycle after the request transfer. The output register
// is freed in the same cycle it is read, so requests stall only while a response waits.
module led_blink_code_sequencer import lbc_pkg::*; #(
	parameter int TIME_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lbc_in_if.sink    req,
	lbc_out_if.source rsp
);

	logic                 acc;
	logic                 free;
	logic [TIME_BITS-1:0] blink_in;
	logic [TIME_BITS-1:0] gap_in;
	logic [TIME_BITS-1:0] pause_in;
	res_t                 res;

	// request transfer whenever the output register can take the result
	assign req.ready = free;
	assign acc       = req.valid && free;

	// lengths cut or widened to the tick counter width
	assign blink_in = TIME_BITS'(req.blink_len);
	assign gap_in   = TIME_BITS'(req.gap_len);
	assign pause_in = TIME_BITS'(req.pause_len);

	lbc_seq_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.mode     (req.mode),
		.code     (req.code),
		.blink_in (blink_in),
		.gap_in   (gap_in),
		.pause_in (pause_in),
		.res      (res)
	);

	// result held until the response transfer
	lbc_result_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (acc),
		.d      (res),
		.free   (free),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/core/lbc_seq_core.sv =====
// sequencer state, next-phase logic and per-item result
`include "led_blink_code_sequencer_macros.svh"

module lbc_seq_core import lbc_pkg::*; #(
	parameter int TIME_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic                 mode,
	input  logic [CODE_W-1:0]    code,
	input  logic [TIME_BITS-1:0] blink_in,
	input  logic [TIME_BITS-1:0] gap_in,
	input  logic [TIME_BITS-1:0] pause_in,
	output res_t                 res
);

	phase_t               phase_q, phase_d;
	logic [TIME_BITS-1:0] ticks_q, ticks_d, ticks_dec;
	logic [TIME_BITS-1:0] blink_q, gap_q, pause_q;
	logic [TIME_BITS-1:0] src_blink, src_gap, src_pause;
	logic [TENS_W-1:0]    pulses_q, pulses_d, pulses_dec;
	logic [UNITS_W-1:0]   units_q, src_units;
	digits_t              dig;
	entry_t               entry;
	logic                 use_entry;
	logic                 running;
	logic                 is_start;

	assign running    = (phase_q != PH_IDLE);
	assign is_start   = mode && !running;
	assign dig        = split_digits(code);
	assign src_blink  = is_start ? blink_in : blink_q;
	assign src_gap    = is_start ? gap_in : gap_q;
	assign src_pause  = is_start ? pause_in : pause_q;
	assign src_units  = is_start ? dig.units : units_q;
	assign ticks_dec  = ticks_q - TIME_BITS'(1);
	assign pulses_dec = pulses_q - TENS_W'(1);

	// next state
	always_comb begin
		phase_d   = phase_q;
		ticks_d   = ticks_q;
		pulses_d  = pulses_q;
		entry     = EN_DONE;
		use_entry = 1'b0;
		if (is_start) begin
			use_entry = 1'b1;
			entry     = EN_TENS;
		end else if (!mode && running) begin
			if (ticks_dec != '0) begin
				ticks_d = ticks_dec;
			end else begin
				unique case (phase_q)
					PH_TENS_ON: begin
						phase_d = PH_TENS_OFF;
						ticks_d = src_blink;
					end
					PH_TENS_OFF: begin
						pulses_d = pulses_dec;
						if (pulses_dec != '0) begin
							phase_d = PH_TENS_ON;
							ticks_d = src_blink;
						end else begin
							use_entry = 1'b1;
							entry     = EN_GAP;
						end
					end
					PH_GAP: begin
						use_entry = 1'b1;
						entry     = EN_UNITS;
					end
					PH_UNITS_ON: begin
						phase_d = PH_UNITS_OFF;
						ticks_d = src_blink;
					end
					PH_UNITS_OFF: begin
						pulses_d = pulses_dec;
						if (pulses_dec != '0) begin
							phase_d = PH_UNITS_ON;
							ticks_d = src_blink;
						end else begin
							use_entry = 1'b1;
							entry     = EN_PAUSE;
						end
					end
					PH_PAUSE: begin
						use_entry = 1'b1;
						entry     = EN_DONE;
					end
					PH_IDLE: begin
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
						ticks_d = '0;
					end
				endcase
			end
		end
		// skip forward over zero-length phases
		if (use_entry) begin
			priority if (entry == EN_TENS && dig.tens != '0 && src_blink != '0) begin
				phase_d  = PH_TENS_ON;
				ticks_d  = src_blink;
				pulses_d = dig.tens;
			end else if (entry <= EN_GAP && src_gap != '0) begin
				phase_d  = PH_GAP;
				ticks_d  = src_gap;
				pulses_d = '0;
			end else if (entry <= EN_UNITS && src_units != '0 && src_blink != '0) begin
				phase_d  = PH_UNITS_ON;
				ticks_d  = src_blink;
				pulses_d = TENS_W'(src_units);
			end else if (entry <= EN_PAUSE && src_pause != '0) begin
				phase_d  = PH_PAUSE;
				ticks_d  = src_pause;
				pulses_d = '0;
			end else begin
				phase_d  = PH_IDLE;
				ticks_d  = '0;
				pulses_d = '0;
			end
		end
	end

	// result of the item
	always_comb begin
		res = '0;
		if (mode && running) begin
			res.rejected = 1'b1;
			res.busy_res = 1'b1;
			res.led      = lit(phase_q);
		end else if (is_start) begin
			res.led      = lit(phase_d);
			res.busy_res = (phase_d != PH_IDLE);
			res.done_res = (phase_d == PH_IDLE);
		end else if (running) begin
			res.led      = lit(phase_q);
			res.busy_res = (phase_d != PH_IDLE);
			res.done_res = (phase_d == PH_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ticks_q  <= '0;
			pulses_q <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			ticks_q  <= ticks_d;
			pulses_q <= pulses_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_start) begin
			blink_q <= blink_in;
			gap_q   <= gap_in;
			pause_q <= pause_in;
			units_q <= dig.units;
		end
	end

	`LBC_ASSERT_NEXT(a_start_enters, clk, arst_n, acc && is_start && !res.done_res, phase_q != PH_IDLE)
	`LBC_ASSERT_NEXT(a_reject_holds, clk, arst_n, acc && mode && running, $stable(phase_q) && $stable(ticks_q))
	`LBC_ASSERT_IMPL(a_pulses_live, clk, arst_n, phase_q == PH_TENS_ON || phase_q == PH_TENS_OFF || phase_q == PH_UNITS_ON || phase_q == PH_UNITS_OFF, pulses_q != '0)
	`LBC_ASSERT_IMPL(a_ticks_live, clk, arst_n, running, ticks_q != '0)

endmodule

// ===== rtl/core/lbc_result_reg.sv =====
// output register between the sequencer and the response channel
module lbc_result_reg import lbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t d,
	output logic free,
	lbc_out_if.source rsp
);

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.led      = res_q.led;
	assign rsp.busy_res = res_q.busy_res;
	assign rsp.done_res = res_q.done_res;
	assign rsp.rejected = res_q.rejected;

endmodule
